// ===== hw/rtl/svsu_pkg.sv =====
package svsu_pkg;

	localparam logic [2:0] ACT_PUSH  = 3'd0;
	localparam logic [2:0] ACT_POP   = 3'd1;
	localparam logic [2:0] ACT_READ  = 3'd2;
	localparam logic [2:0] ACT_FIND  = 3'd3;
	localparam logic [2:0] ACT_CLEAR = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
		logic [7:0]         position;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] data;
		logic [7:0]         found_index;
		logic [8:0]         fill_count;
	} out_word_t;

	typedef struct packed {
		logic valid;
		logic find;
		logic hit;
	} probe_ctl_t;

	typedef enum logic {
		SVSU_IDLE,
		SVSU_BUSY
	} svsu_state_t;

endpackage

// ===== hw/rtl/stack_with_value_search_unit.sv =====
// Bounded stack of DEPTH signed 32-bit words with read at index and a search for the lowest
// index holding a value. Push, clear, failed operations and unknown actions return their
// word in the cycle after acceptance. Pop, a valid read and a find on a non-empty stack send a
// probe down the row of DEPTH storage cells, one cell per cycle; their word enters the output
// register as the probe leaves the last cell, and no new word is taken until that word is out.
// A new word is taken whenever the block is idle and the output register is free or
// being emptied in the same cycle.
module stack_with_value_search_unit #(
	parameter int DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  svsu_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output svsu_pkg::out_word_t out_word
);
	import svsu_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	svsu_state_t        state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic               out_valid_q;
	out_word_t          out_word_q;
	out_word_t          res;
	logic               res_load;
	logic               accept;
	logic               wr_en;
	probe_ctl_t         launch_ctl;
	logic [IW-1:0]      launch_tgt;
	probe_ctl_t         exit_ctl;
	logic signed [31:0] exit_data;
	logic [IW-1:0]      exit_idx;
	logic [CW+7:0]      pos_ext, cnt_ext;
	logic [CW-1:0]      count_m1;
	logic [IW+7:0]      idx_ext;
	logic [CW+8:0]      fill_ext;
	logic               full, empty;

	assign pos_ext  = {{CW{1'b0}}, in_word.position};
	assign cnt_ext  = {8'b0, count_q};
	assign count_m1 = count_q - {{(CW-1){1'b0}}, 1'b1};
	assign idx_ext  = {8'b0, exit_idx};
	assign fill_ext = {9'b0, count_d};
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SVSU_IDLE: begin
				if (accept && launch_ctl.valid) begin
					state_d = SVSU_BUSY;
				end
			end
			SVSU_BUSY: begin
				if (exit_ctl.valid) begin
					state_d = SVSU_IDLE;
				end
			end
			default: state_d = SVSU_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == SVSU_IDLE) && (!out_valid_q || out_ready);
		count_d         = count_q;
		wr_en           = 1'b0;
		launch_ctl      = '0;
		launch_tgt      = pos_ext[IW-1:0];
		res_load        = 1'b0;
		res.status      = ST_OK;
		res.data        = '0;
		res.found_index = '0;
		if (accept) begin
			res_load = 1'b1;
			unique case (in_word.action)
				ACT_PUSH: begin
					if (full) begin
						res.status = ST_FULL;
					end else begin
						wr_en   = 1'b1;
						count_d = count_q + {{(CW-1){1'b0}}, 1'b1};
					end
				end
				ACT_POP: begin
					if (empty) begin
						res.status = ST_EMPTY;
					end else begin
						count_d          = count_m1;
						launch_ctl.valid = 1'b1;
						launch_tgt       = count_m1[IW-1:0];
						res_load         = 1'b0;
					end
				end
				ACT_READ: begin
					if (empty) begin
						res.status = ST_EMPTY;
					end else if (pos_ext >= cnt_ext) begin
						res.status = ST_RANGE;
					end else begin
						launch_ctl.valid = 1'b1;
						res_load         = 1'b0;
					end
				end
				ACT_FIND: begin
					if (empty) begin
						res.status = ST_NOTFOUND;
					end else begin
						launch_ctl.valid = 1'b1;
						launch_ctl.find  = 1'b1;
						res_load         = 1'b0;
					end
				end
				ACT_CLEAR: begin
					count_d = '0;
				end
				default: begin
				end
			endcase
		end else if ((state_q == SVSU_BUSY) && exit_ctl.valid) begin
			res_load = 1'b1;
			if (exit_ctl.find) begin
				if (exit_ctl.hit) begin
					res.found_index = idx_ext[7:0];
				end else begin
					res.status = ST_NOTFOUND;
				end
			end else begin
				res.data = exit_data;
			end
		end
		res.fill_count = fill_ext[8:0];
	end

	svsu_chain #(
		.DEPTH(DEPTH),
		.IW   (IW),
		.CW   (CW)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_word   (in_word.value),
		.fill      (count_q),
		.launch_ctl(launch_ctl),
		.launch_key(in_word.value),
		.launch_tgt(launch_tgt),
		.exit_ctl  (exit_ctl),
		.exit_data (exit_data),
		.exit_idx  (exit_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SVSU_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// ===== hw/rtl/svsu_cell.sv =====
module svsu_cell #(
	parameter int IDX = 0,
	parameter int IW  = 8,
	parameter int CW  = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic signed [31:0]  wr_word,
	input  logic [CW-1:0]       fill,
	input  svsu_pkg::probe_ctl_t ctl_in,
	input  logic signed [31:0]  key_in,
	input  logic [IW-1:0]       tgt_in,
	input  logic signed [31:0]  data_in,
	input  logic [IW-1:0]       idx_in,
	output svsu_pkg::probe_ctl_t ctl_out,
	output logic signed [31:0]  key_out,
	output logic [IW-1:0]       tgt_out,
	output logic signed [31:0]  data_out,
	output logic [IW-1:0]       idx_out
);
	import svsu_pkg::*;

	logic signed [31:0] word_q;
	logic               live;
	logic               matched;
	probe_ctl_t         ctl_d;

	always_comb begin
		live    = ctl_in.valid && !ctl_in.hit;
		matched = 1'b0;
		if (live) begin
			if (ctl_in.find) begin
				matched = (CW'(IDX) < fill) && (word_q == key_in);
			end else begin
				matched = (tgt_in == IW'(IDX));
			end
		end
		ctl_d     = ctl_in;
		ctl_d.hit = ctl_in.hit || matched;
	end

	always_ff @(posedge clk) begin
		if (wr_en && (fill == CW'(IDX))) begin
			word_q <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		key_out  <= key_in;
		tgt_out  <= tgt_in;
		data_out <= matched ? word_q : data_in;
		idx_out  <= matched ? IW'(IDX) : idx_in;
	end

endmodule

// ===== hw/rtl/svsu_chain.sv =====
module svsu_chain #(
	parameter int DEPTH = 256,
	parameter int IW    = 8,
	parameter int CW    = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic signed [31:0]  wr_word,
	input  logic [CW-1:0]       fill,
	input  svsu_pkg::probe_ctl_t launch_ctl,
	input  logic signed [31:0]  launch_key,
	input  logic [IW-1:0]       launch_tgt,
	output svsu_pkg::probe_ctl_t exit_ctl,
	output logic signed [31:0]  exit_data,
	output logic [IW-1:0]       exit_idx
);
	import svsu_pkg::*;

	probe_ctl_t         ctl_w  [DEPTH+1];
	logic signed [31:0] key_w  [DEPTH+1];
	logic [IW-1:0]      tgt_w  [DEPTH+1];
	logic signed [31:0] data_w [DEPTH+1];
	logic [IW-1:0]      idx_w  [DEPTH+1];

	assign ctl_w[0]  = launch_ctl;
	assign key_w[0]  = launch_key;
	assign tgt_w[0]  = launch_tgt;
	assign data_w[0] = '0;
	assign idx_w[0]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		svsu_cell #(
			.IDX(i),
			.IW (IW),
			.CW (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_word (wr_word),
			.fill    (fill),
			.ctl_in  (ctl_w[i]),
			.key_in  (key_w[i]),
			.tgt_in  (tgt_w[i]),
			.data_in (data_w[i]),
			.idx_in  (idx_w[i]),
			.ctl_out (ctl_w[i+1]),
			.key_out (key_w[i+1]),
			.tgt_out (tgt_w[i+1]),
			.data_out(data_w[i+1]),
			.idx_out (idx_w[i+1])
		);
	end

	assign exit_ctl  = ctl_w[DEPTH];
	assign exit_data = data_w[DEPTH];
	assign exit_idx  = idx_w[DEPTH];

endmodule

// ===== hw/rtl/svsu_checker.sv =====
module svsu_checker #(
	parameter int DEPTH = 256
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input svsu_pkg::in_word_t  in_word,
	input logic                out_valid,
	input logic                out_ready,
	input svsu_pkg::out_word_t out_word
);
	import svsu_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_word))
		else $error("input word changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status == ST_FULL) |-> out_word.fill_count == 9'(DEPTH))
		else $error("full reported below capacity");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status == ST_EMPTY)
		|-> (out_word.data == '0) && (out_word.fill_count == '0))
		else $error("empty reported with stored entries or data");

	a_notfound_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status == ST_NOTFOUND)
		|-> (out_word.found_index == '0) && (out_word.data == '0))
		else $error("failed search carries an index or data");

endmodule

bind stack_with_value_search_unit svsu_checker #(
	.DEPTH(DEPTH)
) u_svsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_word  (in_word),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_word (out_word)
);
